// ===== hw/rtl/mfu_pkg.sv =====
// Shared types and constants for the most-frequently-used cache directory.
`timescale 1ns / 1ps

package mfu_pkg;

    localparam int KEY_W   = 32;
    localparam int USES_W  = 32;
    localparam int STAMP_W = 32;
    localparam int TOTAL_W = 32;
    localparam int CAP_W   = 7;

    localparam logic [CAP_W-1:0]  CAP_RESET = 7'd64;
    localparam logic [USES_W-1:0] USES_MAX  = {USES_W{1'b1}};
    localparam logic [USES_W-1:0] USES_ONE  = {{(USES_W-1){1'b0}}, 1'b1};

    // One directory entry as held in the entry memory.
    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [USES_W-1:0]  uses;
        logic [STAMP_W-1:0] stamp;
    } entry_t;

    // Outcome of one scan over the valid entries.
    typedef struct packed {
        logic               hit;
        logic [USES_W-1:0]  hit_uses;
        logic [STAMP_W-1:0] hit_stamp;
        logic [KEY_W-1:0]   vic_key;
    } scan_res_t;

endpackage

// ===== hw/rtl/mfu_dir_mem.sv =====
// Entry memory: one write port, one registered read port.
`timescale 1ns / 1ps

module mfu_dir_mem
    import mfu_pkg::*;
#(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  entry_t            wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output entry_t            rd_data
);

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/mfu_scan_unit.sv =====
// Shared compare unit: tracks the hit entry and the eviction candidate over a scan.
`timescale 1ns / 1ps

module mfu_scan_unit
    import mfu_pkg::*;
#(
    parameter int IDX_W = 6
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [KEY_W-1:0] key,
    input  logic             ent_valid,
    input  logic [IDX_W-1:0] ent_idx,
    input  entry_t           ent,
    output scan_res_t        res,
    output logic [IDX_W-1:0] hit_idx,
    output logic [IDX_W-1:0] vic_idx
);

    logic               hit_reg, hit_next;
    logic [IDX_W-1:0]   hit_idx_reg;
    logic [USES_W-1:0]  hit_uses_reg;
    logic [STAMP_W-1:0] hit_stamp_reg;
    logic               vic_found_reg, vic_found_next;
    logic [IDX_W-1:0]   vic_idx_reg;
    logic [KEY_W-1:0]   vic_key_reg;
    logic [USES_W-1:0]  vic_uses_reg;
    logic [STAMP_W-1:0] vic_stamp_reg;
    logic               take_hit;
    logic               take_vic;

    // Keep the first matching entry; prefer more uses, then the older stamp.
    always_comb begin
        take_hit = ent_valid && !hit_reg && (ent.key == key);
        take_vic = ent_valid && (!vic_found_reg || (ent.uses > vic_uses_reg) ||
                   ((ent.uses == vic_uses_reg) && (ent.stamp < vic_stamp_reg)));
        hit_next       = start ? 1'b0 : (hit_reg || take_hit);
        vic_found_next = start ? 1'b0 : (vic_found_reg || take_vic);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_reg       <= 1'b0;
            vic_found_reg <= 1'b0;
        end else begin
            hit_reg       <= hit_next;
            vic_found_reg <= vic_found_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take_hit) begin
            hit_idx_reg   <= ent_idx;
            hit_uses_reg  <= ent.uses;
            hit_stamp_reg <= ent.stamp;
        end
        if (take_vic) begin
            vic_idx_reg   <= ent_idx;
            vic_key_reg   <= ent.key;
            vic_uses_reg  <= ent.uses;
            vic_stamp_reg <= ent.stamp;
        end
    end

    assign res.hit       = hit_reg;
    assign res.hit_uses  = hit_uses_reg;
    assign res.hit_stamp = hit_stamp_reg;
    assign res.vic_key   = vic_key_reg;
    assign hit_idx       = hit_idx_reg;
    assign vic_idx       = vic_idx_reg;

endmodule

// ===== hw/rtl/mfu_cache_replacement.sv =====
// Top level of the most-frequently-used cache directory: sequencer and result register.
`timescale 1ns / 1ps
//
// Usage:
//   s_valid/s_ready carries one access (s_key, s_last_in_sequence). m_valid/m_ready
//   carries one result per access (hit, evicted, evicted key, eviction total).
//   cfg_wr_en/cfg_wr_data writes the capacity register; write it only while idle.
// Timing:
//   An access scans the valid entries one per cycle through the entry memory and
//   a shared compare unit, then updates one entry. A result becomes valid when
//   that update is made, and the update waits while the output register is full.
//   s_ready rises together with m_valid, so a new access is taken only after
//   the previous one has been scanned and its entry updated.
// Reset:
//   aresetn (synchronous, active low) empties the directory through the fill
//   count, clears stamp and eviction total, and sets capacity to 64. No clearing
//   pass is needed: valid entries always form the prefix below the fill count.
// Stall:
//   A result waits in the output register while m_ready is low; the next access
//   is still taken and scanned, and its update holds until the register frees.
//
module mfu_cache_replacement
    import mfu_pkg::*;
#(
    parameter int WAYS = 64
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [CAP_W-1:0]   cfg_wr_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [KEY_W-1:0]   s_key,
    input  logic               s_last_in_sequence,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_hit,
    output logic               m_evicted,
    output logic [KEY_W-1:0]   m_evicted_key,
    output logic [TOTAL_W-1:0] m_eviction_total
);

    localparam int IDX_W = $clog2(WAYS);
    localparam int OCC_W = $clog2(WAYS + 1);
    localparam int CMP_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_UPDATE = 2'd2;

    logic [1:0]         state_reg, state_next;
    logic [CAP_W-1:0]   cap_reg, cap_next;
    logic [OCC_W-1:0]   occ_reg, occ_next;
    logic [STAMP_W-1:0] stamp_reg, stamp_next;
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic [OCC_W-1:0]   rd_cnt_reg, rd_cnt_next;
    logic               rd_pend_reg;
    logic [IDX_W-1:0]   rd_idx_d_reg;
    logic [KEY_W-1:0]   key_reg;
    logic               last_reg;

    logic               m_valid_reg, m_valid_next;
    logic               m_hit_reg;
    logic               m_evicted_reg;
    logic [KEY_W-1:0]   m_evicted_key_reg;
    logic [TOTAL_W-1:0] m_total_reg;

    logic               in_xfer;
    logic               rd_issue;
    logic               scan_start;
    logic               out_free;
    logic               do_update;
    logic [CMP_W-1:0]   cap_ext;
    logic [CMP_W-1:0]   cap_eff;
    logic               room;

    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    entry_t             wr_data;
    entry_t             rd_data;
    scan_res_t          scan_res;
    logic [IDX_W-1:0]   hit_idx;
    logic [IDX_W-1:0]   vic_idx;

    logic               res_hit;
    logic               res_evicted;
    logic [KEY_W-1:0]   res_evicted_key;

    assign s_ready    = (state_reg == ST_IDLE);
    assign in_xfer    = s_valid && s_ready;
    assign scan_start = in_xfer;
    assign rd_issue   = (state_reg == ST_SCAN) && (rd_cnt_reg < occ_reg);
    assign out_free   = !m_valid_reg || m_ready;
    assign do_update  = (state_reg == ST_UPDATE) && out_free;

    // Clamp capacity: zero acts as one, anything above WAYS acts as WAYS.
    always_comb begin
        cap_ext = CMP_W'(cap_reg);
        priority if (cap_ext == '0) begin
            cap_eff = CMP_W'(1);
        end else if (cap_ext > CMP_W'(WAYS)) begin
            cap_eff = CMP_W'(WAYS);
        end else begin
            cap_eff = cap_ext;
        end
        room = CMP_W'(occ_reg) < cap_eff;
    end

    // Decide the update: bump on hit, fill the next free entry, else replace victim.
    always_comb begin
        wr_en           = do_update;
        wr_addr         = vic_idx;
        wr_data.key     = key_reg;
        wr_data.uses    = USES_ONE;
        wr_data.stamp   = stamp_reg;
        res_hit         = 1'b0;
        res_evicted     = 1'b0;
        res_evicted_key = '0;
        priority if (scan_res.hit) begin
            res_hit       = 1'b1;
            wr_addr       = hit_idx;
            wr_data.uses  = (scan_res.hit_uses == USES_MAX) ? USES_MAX
                                                           : scan_res.hit_uses + USES_ONE;
            wr_data.stamp = scan_res.hit_stamp;
        end else if (room) begin
            wr_addr = occ_reg[IDX_W-1:0];
        end else begin
            res_evicted     = 1'b1;
            res_evicted_key = scan_res.vic_key;
        end
    end

    // Sequencer.
    always_comb begin
        state_next  = state_reg;
        cap_next    = cfg_wr_en ? cfg_wr_data : cap_reg;
        occ_next    = occ_reg;
        stamp_next  = stamp_reg;
        total_next  = total_reg;
        rd_cnt_next = rd_cnt_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    stamp_next  = stamp_reg + STAMP_W'(1);
                    rd_cnt_next = '0;
                    state_next  = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (rd_issue) begin
                    rd_cnt_next = rd_cnt_reg + OCC_W'(1);
                end else if (!rd_pend_reg) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                if (do_update) begin
                    state_next = ST_IDLE;
                    if (!scan_res.hit && room) begin
                        occ_next = occ_reg + OCC_W'(1);
                    end else if (!scan_res.hit) begin
                        total_next = total_reg + TOTAL_W'(1);
                    end
                    // Drop the whole directory after the last access of a sequence.
                    if (last_reg) begin
                        occ_next   = '0;
                        stamp_next = '0;
                        total_next = '0;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold a result until transferred; load a new one only when free.
    always_comb begin
        m_valid_next = m_valid_reg;
        if (do_update) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cap_reg     <= CAP_RESET;
            occ_reg     <= '0;
            stamp_reg   <= '0;
            total_reg   <= '0;
            rd_cnt_reg  <= '0;
            rd_pend_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cap_reg     <= cap_next;
            occ_reg     <= occ_next;
            stamp_reg   <= stamp_next;
            total_reg   <= total_next;
            rd_cnt_reg  <= rd_cnt_next;
            rd_pend_reg <= rd_issue;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rd_idx_d_reg <= rd_cnt_reg[IDX_W-1:0];
        if (in_xfer) begin
            key_reg  <= s_key;
            last_reg <= s_last_in_sequence;
        end
        if (do_update) begin
            m_hit_reg         <= res_hit;
            m_evicted_reg     <= res_evicted;
            m_evicted_key_reg <= res_evicted_key;
            m_total_reg       <= res_evicted ? total_reg + TOTAL_W'(1) : total_reg;
        end
    end

    mfu_dir_mem #(
        .DEPTH  (WAYS),
        .ADDR_W (IDX_W)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_cnt_reg[IDX_W-1:0]),
        .rd_data (rd_data)
    );

    mfu_scan_unit #(
        .IDX_W (IDX_W)
    ) u_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (scan_start),
        .key       (key_reg),
        .ent_valid (rd_pend_reg),
        .ent_idx   (rd_idx_d_reg),
        .ent       (rd_data),
        .res       (scan_res),
        .hit_idx   (hit_idx),
        .vic_idx   (vic_idx)
    );

    assign m_valid          = m_valid_reg;
    assign m_hit            = m_hit_reg;
    assign m_evicted        = m_evicted_reg;
    assign m_evicted_key    = m_evicted_key_reg;
    assign m_eviction_total = m_total_reg;

    // Fill count never passes the directory size.
    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        CMP_W'(occ_reg) <= CMP_W'(WAYS))
        else $error("occupancy exceeds directory size");

    // A result is never both a hit and an eviction.
    a_hit_evict_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_hit && m_evicted))
        else $error("hit and eviction reported together");

    // An eviction only happens when no key matched, there is no room and the directory is not empty.
    a_evict_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        do_update && res_evicted |-> !scan_res.hit && !room && (occ_reg != '0))
        else $error("eviction with room or empty directory");

    // An accepted access moves the block out of idle, so s_ready drops after the transfer.
    a_busy_after_xfer: assert property (@(posedge aclk) disable iff (!aresetn)
        in_xfer |=> !s_ready)
        else $error("input ready right after a transfer");

endmodule
